>>> design/drp_pkg.sv
// ---------------------------------------------------------------------------
// drp_pkg: shared types and codes of the DNS response parser
// Request and token structs, token kinds, error codes, sequencer enums.
// ---------------------------------------------------------------------------
`default_nettype none

package drp_pkg;

    // Default sizes
    localparam int MSG_BYTES_DEF = 512;
    localparam int MAX_HOPS_DEF  = 16;

    // Header and record field sizes in bytes, and the accumulator width in bits
    localparam int HDR_BYTES    = 12;
    localparam int FIELDS_BYTES = 10;
    localparam int QTAIL_BYTES  = 4;
    localparam int ACC_BITS     = 8 * HDR_BYTES;

    // Request codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_FETCH = 1'b1;

    // Token kinds
    localparam logic [2:0] KIND_IDLE   = 3'd0;
    localparam logic [2:0] KIND_HDR    = 3'd1;
    localparam logic [2:0] KIND_COUNTS = 3'd2;
    localparam logic [2:0] KIND_CHAR   = 3'd3;
    localparam logic [2:0] KIND_FIELDS = 3'd4;
    localparam logic [2:0] KIND_RDATA  = 3'd5;
    localparam logic [2:0] KIND_END    = 3'd6;
    localparam logic [2:0] KIND_ERR    = 3'd7;

    // Error codes
    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_SHORT = 2'd1;
    localparam logic [1:0] ERR_PAST  = 2'd2;
    localparam logic [1:0] ERR_HOPS  = 2'd3;

    // Name encoding
    localparam logic [1:0]  COMP_MARK = 2'b11;
    localparam int          OFS_BITS  = 14;
    localparam logic [7:0]  DOT_CHAR  = 8'h2E;
    localparam logic [15:0] TYPE_NS   = 16'd2;

    typedef struct packed {
        logic       req_type;
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_req;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [1:0]  section;
        logic [15:0] word_a;
        logic [15:0] word_b;
        logic [31:0] word_c;
        logic [15:0] word_d;
        logic        truncated;
        logic [3:0]  response_code;
        logic [1:0]  error_code;
        logic        last_token;
    } t_out_tok;

    typedef enum logic [3:0] {
        PH_IDLE, PH_HDR1, PH_HDR2, PH_QSKIP, PH_RECSTART,
        PH_NAME, PH_FIELDS, PH_RDATA, PH_END
    } t_phase;

    typedef enum logic [2:0] {
        ST_IDLE, ST_RUN, ST_READ, ST_POST, ST_EMIT
    } t_state;

    typedef enum logic [2:0] {
        OP_HDR, OP_CHAR, OP_DOT, OP_LEN, OP_PTR, OP_FIELDS, OP_RDATA
    } t_op;

endpackage

`default_nettype wire

>>> design/drp_ram.sv
// ---------------------------------------------------------------------------
// drp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
`default_nettype none

module drp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output      logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

>>> design/dns_response_parser_unit.sv
// Flow: a load is written to the store directly; a fetch reads its bytes through the registered
//   RAM port, acts on them and emits a token; one-byte reads that give no token (length byte,
//   dot check, skipped byte) and pointer hops come on the way before the token is emitted.
// Throughput: one request at a time; the single RAM read port sets the pace.
//   Loads are taken while a finished token waits in the output register.
// Reset: synchronous, active low; clears all control state, the parse goes idle.
// ---------------------------------------------------------------------------
// dns_response_parser_unit: DNS message parser with name compression
// Stores message bytes, then returns one parsed token per fetch request.
// ---------------------------------------------------------------------------
`default_nettype none

module dns_response_parser_unit #(
    parameter int MSG_BYTES = drp_pkg::MSG_BYTES_DEF,
    parameter int MAX_HOPS  = drp_pkg::MAX_HOPS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output      logic             o_in_stall,
    input  wire drp_pkg::t_in_req i_in_req,
    output      logic             o_out_valid,
    input  wire logic             i_out_stall,
    output      drp_pkg::t_out_tok o_out_tok
);

    localparam int AW  = $clog2(MSG_BYTES);
    localparam int CW  = $clog2(MSG_BYTES + 1);
    localparam int PW  = CW + 17;
    localparam int HW  = $clog2(MAX_HOPS + 1);
    localparam int ABW = drp_pkg::ACC_BITS;

    // Control state
    drp_pkg::t_state r_state, n_state;
    drp_pkg::t_phase r_phase, n_phase;
    drp_pkg::t_op    r_op, n_op;
    logic [CW-1:0]   r_load_cnt, n_load_cnt;
    logic [CW-1:0]   r_msg_len, n_msg_len;
    logic [PW-1:0]   r_ptr, n_ptr;
    logic [PW-1:0]   r_resume, n_resume;
    logic [PW-1:0]   r_rec_end, n_rec_end;
    logic            r_jumped, n_jumped;
    logic [HW-1:0]   r_hop, n_hop;
    logic [15:0]     r_cnt [4];
    logic [15:0]     n_cnt [4];
    logic [7:0]      r_label, n_label;
    logic [15:0]     r_rdrem, n_rdrem;
    logic            r_dot, n_dot;
    logic            r_in_rdata, n_in_rdata;
    logic [3:0]      r_rd_left, n_rd_left;
    logic            r_rd_pend, n_rd_pend;
    logic            r_out_valid;

    // Payload
    logic [PW-1:0]     r_rd_addr, n_rd_addr;
    logic [ABW-1:0]    r_acc, n_acc;
    logic [15:0]       r_flags, n_flags;
    logic [15:0]       r_qd, n_qd;
    logic [15:0]       r_an, n_an;
    drp_pkg::t_out_tok r_tok, n_tok;
    drp_pkg::t_out_tok r_out;

    logic          in_acc;
    logic          out_free;
    logic          ram_we;
    logic [AW-1:0] ram_raddr;
    logic [7:0]    ram_rdata;
    logic [1:0]    sec;
    logic [1:0]    sec_idx;
    logic [7:0]    post_b;
    logic          rd_ok;
    logic [15:0]   dec_cnt [4];

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != drp_pkg::ST_IDLE);
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_tok   = r_out;
    assign ram_we      = in_acc && (i_in_req.req_type == drp_pkg::REQ_LOAD)
                         && (r_load_cnt < CW'(MSG_BYTES));
    assign post_b      = r_acc[7:0];
    assign rd_ok       = r_rd_addr < PW'(r_msg_len);
    assign ram_raddr   = r_rd_addr[AW-1:0];

    drp_ram #(
        .WIDTH (8),
        .DEPTH (MSG_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_load_cnt[AW-1:0]),
        .i_wdata (i_in_req.data_byte),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Current section: first nonzero of an, ns, ar counts
    always_comb begin
        priority if (r_cnt[1] != 16'd0) begin
            sec = 2'd0;
        end else if (r_cnt[2] != 16'd0) begin
            sec = 2'd1;
        end else if (r_cnt[3] != 16'd0) begin
            sec = 2'd2;
        end else begin
            sec = 2'd0;
        end
        sec_idx = sec + 2'd1;
        for (int k = 0; k < 4; k++) begin
            dec_cnt[k] = r_cnt[k];
        end
        dec_cnt[sec_idx] = r_cnt[sec_idx] - 16'd1;
    end

    // Sequencer: next state and datapath
    always_comb begin
        n_state    = r_state;
        n_phase    = r_phase;
        n_op       = r_op;
        n_load_cnt = r_load_cnt;
        n_msg_len  = r_msg_len;
        n_ptr      = r_ptr;
        n_resume   = r_resume;
        n_rec_end  = r_rec_end;
        n_jumped   = r_jumped;
        n_hop      = r_hop;
        for (int k = 0; k < 4; k++) begin
            n_cnt[k] = r_cnt[k];
        end
        n_label    = r_label;
        n_rdrem    = r_rdrem;
        n_dot      = r_dot;
        n_in_rdata = r_in_rdata;
        n_rd_left  = r_rd_left;
        n_rd_pend  = r_rd_pend;
        n_rd_addr  = r_rd_addr;
        n_acc      = r_acc;
        n_flags    = r_flags;
        n_qd       = r_qd;
        n_an       = r_an;
        n_tok      = r_tok;

        unique case (r_state)
            drp_pkg::ST_IDLE: begin
                if (in_acc) begin
                    if (i_in_req.req_type == drp_pkg::REQ_LOAD) begin
                        n_phase = drp_pkg::PH_IDLE;
                        if (r_load_cnt < CW'(MSG_BYTES)) begin
                            n_load_cnt = r_load_cnt + CW'(1);
                        end
                        if (i_in_req.last_byte) begin
                            n_msg_len  = n_load_cnt;
                            n_load_cnt = '0;
                            n_phase    = drp_pkg::PH_HDR1;
                        end
                    end else begin
                        n_tok   = '0;
                        n_state = drp_pkg::ST_RUN;
                    end
                end
            end

            // Dispatch on the parse phase
            drp_pkg::ST_RUN: begin
                unique case (r_phase)
                    drp_pkg::PH_IDLE: begin
                        n_tok   = '0;
                        n_state = drp_pkg::ST_EMIT;
                    end
                    drp_pkg::PH_HDR1: begin
                        if (r_msg_len < CW'(drp_pkg::HDR_BYTES)) begin
                            n_tok.token_kind = drp_pkg::KIND_ERR;
                            n_tok.error_code = drp_pkg::ERR_SHORT;
                            n_tok.last_token = 1'b1;
                            n_phase          = drp_pkg::PH_IDLE;
                            n_state          = drp_pkg::ST_EMIT;
                        end else begin
                            n_rd_addr = '0;
                            n_rd_left = 4'(drp_pkg::HDR_BYTES);
                            n_op      = drp_pkg::OP_HDR;
                            n_state   = drp_pkg::ST_READ;
                        end
                    end
                    drp_pkg::PH_HDR2: begin
                        n_tok.token_kind    = drp_pkg::KIND_COUNTS;
                        n_tok.word_a        = r_cnt[2];
                        n_tok.word_b        = r_cnt[3];
                        n_tok.word_c        = {16'd0, r_qd};
                        n_tok.word_d        = r_an;
                        n_tok.truncated     = r_flags[9];
                        n_tok.response_code = r_flags[3:0];
                        if (r_cnt[1] == 16'd0 && r_cnt[2] == 16'd0 && r_cnt[3] == 16'd0) begin
                            n_tok.last_token = 1'b1;
                            n_phase          = drp_pkg::PH_IDLE;
                        end else begin
                            n_ptr      = PW'(drp_pkg::HDR_BYTES);
                            n_phase    = drp_pkg::PH_QSKIP;
                            n_jumped   = 1'b0;
                            n_hop      = '0;
                            n_label    = '0;
                            n_dot      = 1'b0;
                            n_in_rdata = 1'b0;
                        end
                        n_state = drp_pkg::ST_EMIT;
                    end
                    drp_pkg::PH_QSKIP, drp_pkg::PH_NAME: begin
                        if (r_phase == drp_pkg::PH_QSKIP && r_cnt[0] == 16'd0) begin
                            n_phase = drp_pkg::PH_RECSTART;
                        end else begin
                            n_rd_addr = r_ptr;
                            n_rd_left = 4'd1;
                            n_state   = drp_pkg::ST_READ;
                            priority if (r_label != 8'd0) begin
                                n_op = drp_pkg::OP_CHAR;
                            end else if (r_dot) begin
                                n_op = drp_pkg::OP_DOT;
                            end else begin
                                n_op = drp_pkg::OP_LEN;
                            end
                        end
                    end
                    drp_pkg::PH_RECSTART: begin
                        n_jumped   = 1'b0;
                        n_hop      = '0;
                        n_label    = '0;
                        n_dot      = 1'b0;
                        n_in_rdata = 1'b0;
                        n_phase    = drp_pkg::PH_NAME;
                    end
                    drp_pkg::PH_FIELDS: begin
                        n_rd_addr = r_ptr;
                        n_rd_left = 4'(drp_pkg::FIELDS_BYTES);
                        n_op      = drp_pkg::OP_FIELDS;
                        n_state   = drp_pkg::ST_READ;
                    end
                    drp_pkg::PH_RDATA: begin
                        if (r_rdrem == 16'd0) begin
                            n_phase = drp_pkg::PH_END;
                        end else begin
                            n_rd_addr = r_ptr;
                            n_rd_left = 4'd1;
                            n_op      = drp_pkg::OP_RDATA;
                            n_state   = drp_pkg::ST_READ;
                        end
                    end
                    drp_pkg::PH_END: begin
                        n_ptr            = r_rec_end;
                        n_tok.token_kind = drp_pkg::KIND_END;
                        n_tok.section    = sec;
                        for (int k = 0; k < 4; k++) begin
                            n_cnt[k] = dec_cnt[k];
                        end
                        if (dec_cnt[1] == 16'd0 && dec_cnt[2] == 16'd0
                                && dec_cnt[3] == 16'd0) begin
                            n_tok.last_token = 1'b1;
                            n_phase          = drp_pkg::PH_IDLE;
                        end else begin
                            n_phase = drp_pkg::PH_RECSTART;
                        end
                        n_state = drp_pkg::ST_EMIT;
                    end
                    default: begin
                        n_tok   = '0;
                        n_phase = drp_pkg::PH_IDLE;
                        n_state = drp_pkg::ST_EMIT;
                    end
                endcase
            end

            // Byte reader: issue one address a cycle, shift its data in on the next cycle
            drp_pkg::ST_READ: begin
                if (r_rd_pend) begin
                    n_acc = {r_acc[ABW-9:0], ram_rdata};
                end
                if (r_rd_left != 4'd0) begin
                    if (!rd_ok) begin
                        n_rd_pend        = 1'b0;
                        n_tok.token_kind = drp_pkg::KIND_ERR;
                        n_tok.error_code = drp_pkg::ERR_PAST;
                        n_tok.last_token = 1'b1;
                        n_phase          = drp_pkg::PH_IDLE;
                        n_state          = drp_pkg::ST_EMIT;
                    end else begin
                        n_rd_addr = r_rd_addr + PW'(1);
                        n_rd_left = r_rd_left - 4'd1;
                        n_rd_pend = 1'b1;
                    end
                end else begin
                    n_rd_pend = 1'b0;
                    n_state   = drp_pkg::ST_POST;
                end
            end

            // Act on the bytes read
            drp_pkg::ST_POST: begin
                n_state = drp_pkg::ST_RUN;
                unique case (r_op)
                    drp_pkg::OP_HDR: begin
                        n_flags             = r_acc[79:64];
                        n_qd                = r_acc[63:48];
                        n_an                = r_acc[47:32];
                        n_cnt[0]            = r_acc[63:48];
                        n_cnt[1]            = r_acc[47:32];
                        n_cnt[2]            = r_acc[31:16];
                        n_cnt[3]            = r_acc[15:0];
                        n_tok.token_kind    = drp_pkg::KIND_HDR;
                        n_tok.word_a        = r_acc[95:80];
                        n_tok.word_b        = r_acc[79:64];
                        n_tok.word_c        = {16'd0, r_acc[63:48]};
                        n_tok.word_d        = r_acc[47:32];
                        n_tok.truncated     = r_acc[73];
                        n_tok.response_code = r_acc[67:64];
                        n_phase             = drp_pkg::PH_HDR2;
                        n_state             = drp_pkg::ST_EMIT;
                    end
                    drp_pkg::OP_CHAR: begin
                        n_ptr   = r_ptr + PW'(1);
                        n_label = r_label - 8'd1;
                        if (r_label == 8'd1) begin
                            n_dot = 1'b1;
                        end
                        if (r_phase == drp_pkg::PH_NAME) begin
                            n_tok.token_kind = drp_pkg::KIND_CHAR;
                            n_tok.section    = sec;
                            n_tok.word_a     = {8'd0, post_b};
                            n_tok.word_b     = {15'd0, r_in_rdata};
                            n_state          = drp_pkg::ST_EMIT;
                        end
                    end
                    drp_pkg::OP_DOT: begin
                        n_dot = 1'b0;
                        if (post_b != 8'd0 && r_phase == drp_pkg::PH_NAME) begin
                            n_tok.token_kind = drp_pkg::KIND_CHAR;
                            n_tok.section    = sec;
                            n_tok.word_a     = {8'd0, drp_pkg::DOT_CHAR};
                            n_tok.word_b     = {15'd0, r_in_rdata};
                            n_state          = drp_pkg::ST_EMIT;
                        end
                    end
                    drp_pkg::OP_LEN: begin
                        priority if (post_b == 8'd0) begin
                            n_ptr = r_jumped ? r_resume : (r_ptr + PW'(1));
                            if (r_phase == drp_pkg::PH_QSKIP) begin
                                n_ptr      = n_ptr + PW'(drp_pkg::QTAIL_BYTES);
                                n_cnt[0]   = r_cnt[0] - 16'd1;
                                n_jumped   = 1'b0;
                                n_hop      = '0;
                                n_label    = '0;
                                n_dot      = 1'b0;
                                n_in_rdata = 1'b0;
                            end else begin
                                n_phase = r_in_rdata ? drp_pkg::PH_END : drp_pkg::PH_FIELDS;
                            end
                        end else if (post_b[7:6] == drp_pkg::COMP_MARK) begin
                            n_rd_addr = r_ptr;
                            n_rd_left = 4'd2;
                            n_op      = drp_pkg::OP_PTR;
                            n_state   = drp_pkg::ST_READ;
                        end else begin
                            n_ptr   = r_ptr + PW'(1);
                            n_label = post_b;
                        end
                    end
                    drp_pkg::OP_PTR: begin
                        if (r_hop >= HW'(MAX_HOPS)) begin
                            n_tok.token_kind = drp_pkg::KIND_ERR;
                            n_tok.error_code = drp_pkg::ERR_HOPS;
                            n_tok.last_token = 1'b1;
                            n_phase          = drp_pkg::PH_IDLE;
                            n_state          = drp_pkg::ST_EMIT;
                        end else begin
                            n_hop = r_hop + HW'(1);
                            if (!r_jumped) begin
                                n_resume = r_ptr + PW'(2);
                                n_jumped = 1'b1;
                            end
                            n_ptr = PW'(r_acc[drp_pkg::OFS_BITS-1:0]);
                        end
                    end
                    drp_pkg::OP_FIELDS: begin
                        n_ptr            = r_ptr + PW'(drp_pkg::FIELDS_BYTES);
                        n_rdrem          = r_acc[15:0];
                        n_rec_end        = r_ptr + PW'(drp_pkg::FIELDS_BYTES)
                                           + PW'(r_acc[15:0]);
                        n_tok.token_kind = drp_pkg::KIND_FIELDS;
                        n_tok.section    = sec;
                        n_tok.word_a     = r_acc[79:64];
                        n_tok.word_b     = r_acc[63:48];
                        n_tok.word_c     = r_acc[47:16];
                        n_tok.word_d     = r_acc[15:0];
                        if (r_acc[79:64] == drp_pkg::TYPE_NS) begin
                            n_jumped   = 1'b0;
                            n_hop      = '0;
                            n_label    = '0;
                            n_dot      = 1'b0;
                            n_in_rdata = 1'b1;
                            n_phase    = drp_pkg::PH_NAME;
                        end else begin
                            n_phase = drp_pkg::PH_RDATA;
                        end
                        n_state = drp_pkg::ST_EMIT;
                    end
                    drp_pkg::OP_RDATA: begin
                        n_ptr            = r_ptr + PW'(1);
                        n_rdrem          = r_rdrem - 16'd1;
                        n_tok.token_kind = drp_pkg::KIND_RDATA;
                        n_tok.section    = sec;
                        n_tok.word_a     = {8'd0, post_b};
                        n_state          = drp_pkg::ST_EMIT;
                    end
                    default: begin
                        n_state = drp_pkg::ST_RUN;
                    end
                endcase
            end

            // Hand the token to the output register
            drp_pkg::ST_EMIT: begin
                if (out_free) begin
                    n_state = drp_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = drp_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= drp_pkg::ST_IDLE;
            r_phase     <= drp_pkg::PH_IDLE;
            r_op        <= drp_pkg::OP_HDR;
            r_load_cnt  <= '0;
            r_msg_len   <= '0;
            r_ptr       <= '0;
            r_resume    <= '0;
            r_rec_end   <= '0;
            r_jumped    <= 1'b0;
            r_hop       <= '0;
            for (int k = 0; k < 4; k++) begin
                r_cnt[k] <= '0;
            end
            r_label     <= '0;
            r_rdrem     <= '0;
            r_dot       <= 1'b0;
            r_in_rdata  <= 1'b0;
            r_rd_left   <= '0;
            r_rd_pend   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_phase    <= n_phase;
            r_op       <= n_op;
            r_load_cnt <= n_load_cnt;
            r_msg_len  <= n_msg_len;
            r_ptr      <= n_ptr;
            r_resume   <= n_resume;
            r_rec_end  <= n_rec_end;
            r_jumped   <= n_jumped;
            r_hop      <= n_hop;
            for (int k = 0; k < 4; k++) begin
                r_cnt[k] <= n_cnt[k];
            end
            r_label    <= n_label;
            r_rdrem    <= n_rdrem;
            r_dot      <= n_dot;
            r_in_rdata <= n_in_rdata;
            r_rd_left  <= n_rd_left;
            r_rd_pend  <= n_rd_pend;
            if (r_state == drp_pkg::ST_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_rd_addr <= n_rd_addr;
        r_acc     <= n_acc;
        r_flags   <= n_flags;
        r_qd      <= n_qd;
        r_an      <= n_an;
        r_tok     <= n_tok;
        if (r_state == drp_pkg::ST_EMIT && out_free) begin
            r_out <= r_tok;
        end
    end

    // Checks
    a_hop_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hop <= HW'(MAX_HOPS))
        else $error("hop count beyond limit");

    a_pend_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_pend |-> $past(r_state == drp_pkg::ST_READ))
        else $error("read data pending outside reader");

    a_fetch_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in_req.req_type == drp_pkg::REQ_FETCH) |=> o_in_stall)
        else $error("fetch request did not start work");

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_tok.token_kind == drp_pkg::KIND_ERR) |-> o_out_tok.last_token)
        else $error("error token not marked last");

    a_emit_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == drp_pkg::ST_EMIT && out_free) |=> o_out_valid)
        else $error("token not presented");

endmodule

`default_nettype wire

>>> tb/tb_dns_response_parser_unit.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_dns_response_parser_unit: self-checking bench of the DNS response parser
// Loads DNS messages byte by byte and fetches tokens. A built-in token
// predictor computes every expected token. Both handshakes are throttled at
// random, and each token is compared field by field in order.
// ---------------------------------------------------------------------------
module tb_dns_response_parser_unit;

    localparam int STORE_BYTES = drp_pkg::MSG_BYTES_DEF;
    localparam int HOP_LIMIT   = drp_pkg::MAX_HOPS_DEF;

    // name walk outcomes
    typedef enum int {W_CHAR, W_DONE, W_BAD_END, W_BAD_HOPS} t_walk;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    drp_pkg::t_in_req  i_in_req = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    drp_pkg::t_out_tok o_out_tok;

    dns_response_parser_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_tok   (o_out_tok)
    );

    always #5 i_clk = ~i_clk;

    // Predictor state
    logic [7:0]      msg_mem [STORE_BYTES];
    int unsigned     fill_cnt, msg_len, rd_ptr, resume_ptr, hops, label_left;
    int unsigned     rdata_left, rec_end;
    int unsigned     sec_left [4];
    bit              jumped, dot_pend, name_is_rdata;
    drp_pkg::t_phase phase;

    // Bench bookkeeping
    drp_pkg::t_out_tok token_q [$];
    drp_pkg::t_out_tok last_pred;
    int                n_items, n_msgs, n_tokens, n_errtok, n_fail;
    bit                calm;
    logic [7:0]        msg [$];
    int unsigned       name_offs [$];

    // ---------------- token predictor ----------------
    function automatic bit read_bytes(int unsigned a, int unsigned n, output int unsigned v);
        v = 0;
        for (int unsigned i = 0; i < n; i++) begin
            if (a + i >= msg_len) return 1'b0;
            v = (v << 8) | msg_mem[a + i];
        end
        return 1'b1;
    endfunction

    function automatic void name_start(bit in_rdata);
        jumped = 0;
        hops = 0;
        label_left = 0;
        dot_pend = 0;
        name_is_rdata = in_rdata;
    endfunction

    function automatic t_walk name_walk(output logic [7:0] ch);
        int unsigned b, w;
        ch = '0;
        while (1) begin
            if (label_left > 0) begin
                if (!read_bytes(rd_ptr, 1, b)) return W_BAD_END;
                rd_ptr++;
                label_left--;
                if (label_left == 0) dot_pend = 1;
                ch = b[7:0];
                return W_CHAR;
            end
            if (dot_pend) begin
                dot_pend = 0;
                if (!read_bytes(rd_ptr, 1, b)) return W_BAD_END;
                if (b != 0) begin
                    ch = drp_pkg::DOT_CHAR;
                    return W_CHAR;
                end
                continue;
            end
            if (!read_bytes(rd_ptr, 1, b)) return W_BAD_END;
            if (b == 0) begin
                rd_ptr = jumped ? resume_ptr : rd_ptr + 1;
                return W_DONE;
            end
            if (b[7:6] == drp_pkg::COMP_MARK) begin
                if (!read_bytes(rd_ptr, 2, w)) return W_BAD_END;
                if (hops >= HOP_LIMIT) return W_BAD_HOPS;
                hops++;
                if (!jumped) begin
                    resume_ptr = rd_ptr + 2;
                    jumped = 1;
                end
                rd_ptr = w & 32'h3FFF;
                continue;
            end
            rd_ptr++;
            label_left = b;
        end
        return W_DONE;
    endfunction

    function automatic int unsigned cur_sec();
        for (int i = 1; i < 4; i++)
            if (sec_left[i] != 0) return i - 1;
        return 0;
    endfunction

    function automatic drp_pkg::t_out_tok err_token(t_walk w);
        drp_pkg::t_out_tok t;
        t = '0;
        t.token_kind = drp_pkg::KIND_ERR;
        t.error_code = (w == W_BAD_HOPS) ? drp_pkg::ERR_HOPS : drp_pkg::ERR_PAST;
        t.last_token = 1'b1;
        phase = drp_pkg::PH_IDLE;
        return t;
    endfunction

    function automatic void header_words(inout drp_pkg::t_out_tok t);
        int unsigned flags, qd, an;
        void'(read_bytes(2, 2, flags));
        void'(read_bytes(4, 2, qd));
        void'(read_bytes(6, 2, an));
        t.word_c = qd;
        t.word_d = an[15:0];
        t.truncated = flags[9];
        t.response_code = flags[3:0];
    endfunction

    function automatic bit all_done();
        return sec_left[1] == 0 && sec_left[2] == 0 && sec_left[3] == 0;
    endfunction

    function automatic void store_byte(logic [7:0] d, logic lb);
        phase = drp_pkg::PH_IDLE;
        if (fill_cnt < STORE_BYTES) begin
            msg_mem[fill_cnt] = d;
            fill_cnt++;
        end
        if (lb) begin
            msg_len = fill_cnt;
            fill_cnt = 0;
            phase = drp_pkg::PH_HDR1;
        end
    endfunction

    function automatic drp_pkg::t_out_tok predict_token();
        drp_pkg::t_out_tok t;
        t_walk             w;
        logic [7:0]        ch;
        int unsigned       v, typ, cls, ttl, len;
        t = '0;
        while (1) begin
            case (phase)
                drp_pkg::PH_HDR1: begin
                    if (msg_len < drp_pkg::HDR_BYTES) begin
                        t = err_token(W_BAD_END);
                        t.error_code = drp_pkg::ERR_SHORT;
                        return t;
                    end
                    for (int i = 0; i < 4; i++) void'(read_bytes(4 + 2 * i, 2, sec_left[i]));
                    t.token_kind = drp_pkg::KIND_HDR;
                    void'(read_bytes(0, 2, v));
                    t.word_a = v[15:0];
                    void'(read_bytes(2, 2, v));
                    t.word_b = v[15:0];
                    header_words(t);
                    phase = drp_pkg::PH_HDR2;
                    return t;
                end
                drp_pkg::PH_HDR2: begin
                    t.token_kind = drp_pkg::KIND_COUNTS;
                    t.word_a = sec_left[2][15:0];
                    t.word_b = sec_left[3][15:0];
                    header_words(t);
                    if (all_done()) begin
                        t.last_token = 1'b1;
                        phase = drp_pkg::PH_IDLE;
                    end else begin
                        rd_ptr = drp_pkg::HDR_BYTES;
                        phase = drp_pkg::PH_QSKIP;
                    end
                    return t;
                end
                drp_pkg::PH_QSKIP: begin
                    while (sec_left[0] != 0) begin
                        name_start(0);
                        do w = name_walk(ch); while (w == W_CHAR);
                        if (w != W_DONE) return err_token(w);
                        rd_ptr += drp_pkg::QTAIL_BYTES;
                        sec_left[0]--;
                    end
                    phase = drp_pkg::PH_RECSTART;
                end
                drp_pkg::PH_RECSTART: begin
                    name_start(0);
                    phase = drp_pkg::PH_NAME;
                end
                drp_pkg::PH_NAME: begin
                    w = name_walk(ch);
                    if (w == W_CHAR) begin
                        t.token_kind = drp_pkg::KIND_CHAR;
                        t.section = 2'(cur_sec());
                        t.word_a = {8'h00, ch};
                        t.word_b = {15'd0, name_is_rdata};
                        return t;
                    end
                    if (w != W_DONE) return err_token(w);
                    phase = name_is_rdata ? drp_pkg::PH_END : drp_pkg::PH_FIELDS;
                end
                drp_pkg::PH_FIELDS: begin
                    if (!read_bytes(rd_ptr, 2, typ) || !read_bytes(rd_ptr + 2, 2, cls) ||
                        !read_bytes(rd_ptr + 4, 4, ttl) || !read_bytes(rd_ptr + 8, 2, len))
                        return err_token(W_BAD_END);
                    rd_ptr += drp_pkg::FIELDS_BYTES;
                    rdata_left = len;
                    rec_end = rd_ptr + len;
                    t.token_kind = drp_pkg::KIND_FIELDS;
                    t.section = 2'(cur_sec());
                    t.word_a = typ[15:0];
                    t.word_b = cls[15:0];
                    t.word_c = ttl;
                    t.word_d = len[15:0];
                    if (typ[15:0] == drp_pkg::TYPE_NS) begin
                        name_start(1);
                        phase = drp_pkg::PH_NAME;
                    end else begin
                        phase = drp_pkg::PH_RDATA;
                    end
                    return t;
                end
                drp_pkg::PH_RDATA: begin
                    if (rdata_left == 0) begin
                        phase = drp_pkg::PH_END;
                        continue;
                    end
                    if (!read_bytes(rd_ptr, 1, v)) return err_token(W_BAD_END);
                    rd_ptr++;
                    rdata_left--;
                    t.token_kind = drp_pkg::KIND_RDATA;
                    t.section = 2'(cur_sec());
                    t.word_a = v[15:0];
                    return t;
                end
                drp_pkg::PH_END: begin
                    rd_ptr = rec_end;
                    t.token_kind = drp_pkg::KIND_END;
                    t.section = 2'(cur_sec());
                    sec_left[cur_sec() + 1]--;
                    if (all_done()) begin
                        t.last_token = 1'b1;
                        phase = drp_pkg::PH_IDLE;
                    end else begin
                        phase = drp_pkg::PH_RECSTART;
                    end
                    return t;
                end
                default: begin
                    phase = drp_pkg::PH_IDLE;
                    return t;
                end
            endcase
        end
        return t;
    endfunction

    // ---------------- request driver ----------------
    task automatic send(input logic rt, input logic [7:0] db, input logic lb);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 8);
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req <= '{req_type: rt, data_byte: db, last_byte: lb};
        do @(posedge i_clk); while (o_in_stall);
        n_items++;
        if (rt == drp_pkg::REQ_LOAD) begin
            store_byte(db, lb);
        end else begin
            last_pred = predict_token();
            if (last_pred.token_kind == drp_pkg::KIND_ERR) n_errtok++;
            token_q = {token_q, last_pred};
        end
    endtask

    task automatic fetch();
        send(drp_pkg::REQ_FETCH, 8'($urandom), 1'($urandom));
    endtask

    // hold the request side until every pending token is back
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (token_q.size() != 0) @(posedge i_clk);
    endtask

    // load msg[], then fetch until the last token or the cap, and at random one fetch more
    task automatic run_message(input int cap);
        int n;
        n_msgs++;
        foreach (msg[i]) send(drp_pkg::REQ_LOAD, msg[i], i == msg.size() - 1);
        n = 0;
        do begin
            fetch();
            n++;
        end while (!last_pred.last_token && n < cap);
        repeat ($urandom_range(0, 1)) fetch();
    endtask

    // ---------------- message builder ----------------
    function automatic void put8(logic [7:0] b);
        msg = {msg, b};
    endfunction

    function automatic void put16(int unsigned v);
        put8(v[15:8]);
        put8(v[7:0]);
    endfunction

    function automatic void put_header(int unsigned qd, an, ns, ar);
        msg.delete();
        name_offs.delete();
        put16($urandom);
        put16($urandom);
        put16(qd);
        put16(an);
        put16(ns);
        put16(ar);
    endfunction

    function automatic void put_name();
        int unsigned start, len, off;
        start = msg.size();
        repeat ($urandom_range(0, 3)) begin
            len = ($urandom_range(0, 15) == 0) ? 8'h41 : $urandom_range(1, 5);
            put8(len[7:0]);
            repeat (len) put8(8'($urandom));
        end
        if (name_offs.size() > 0 && $urandom_range(0, 1)) begin
            off = name_offs[$urandom_range(0, name_offs.size() - 1)];
            put16(16'hC000 | off);
        end else begin
            put8(8'h00);
        end
        if (msg.size() > start + 1) name_offs = {name_offs, start};
    endfunction

    function automatic void build_random();
        int unsigned qd, an, ns, ar, typ, p, s, rl;
        qd = $urandom_range(0, 2);
        an = $urandom_range(0, 3);
        ns = $urandom_range(0, 2);
        ar = $urandom_range(0, 2);
        if ($urandom_range(0, 9) == 0) {an, ns, ar} = '0;
        put_header(qd, an, ns, ar);
        repeat (qd) begin
            put_name();
            put16($urandom);
            put16($urandom);
        end
        repeat (an + ns + ar) begin
            put_name();
            case ($urandom_range(0, 3))
                0: typ = 1;
                1: typ = drp_pkg::TYPE_NS;
                2: typ = 28;
                default: typ = $urandom_range(0, 65535);
            endcase
            put16(typ);
            put16($urandom);
            put16($urandom);
            put16($urandom);
            p = msg.size();
            put16(0);
            s = msg.size();
            if (typ == drp_pkg::TYPE_NS) put_name();
            else repeat ($urandom_range(0, 6)) put8(8'($urandom));
            rl = msg.size() - s;
            if ($urandom_range(0, 9) == 0) rl = $urandom_range(0, 20);
            msg[p] = rl[15:8];
            msg[p + 1] = rl[7:0];
        end
        // occasional damage: cut short or one byte overwritten
        case ($urandom_range(0, 9))
            0: begin
                rl = $urandom_range(drp_pkg::HDR_BYTES, msg.size());
                while (msg.size() > rl) void'(msg.pop_back());
            end
            1: msg[$urandom_range(0, msg.size() - 1)] = 8'($urandom);
            default: ;
        endcase
    endfunction

    // ---------------- tests ----------------
    task automatic test_idle_fetch();
        fetch();
        fetch();
    endtask

    task automatic test_header_only();
        put_header(16'hFFFF, 0, 0, 0);
        msg[0] = 8'hFF; msg[1] = 8'hFF; msg[2] = 8'hFF; msg[3] = 8'hFF;
        run_message(4);
        put_header(0, 0, 0, 0);
        msg[2] = 8'h00; msg[3] = 8'h00;
        run_message(4);
    endtask

    task automatic test_short_message();
        msg.delete();
        repeat (drp_pkg::HDR_BYTES - 1) put8(8'($urandom));
        run_message(3);
        msg.delete();
        put8(8'hA5);
        run_message(3);
    endtask

    task automatic test_pointer_loop();
        put_header(0, 1, 0, 0);
        put16(16'hC000 | drp_pkg::HDR_BYTES);
        run_message(4);
    endtask

    task automatic test_read_past_end();
        put_header(0, 1, 0, 0);
        put8(8'h01);
        put8("a");
        put8(8'h00);
        put16(1);
        run_message(8);
    endtask

    task automatic test_ns_and_odd_length();
        put_header(1, 1, 0, 0);
        put8(8'h01); put8("q"); put8(8'h00);
        put16(1); put16(1);
        put16(16'hC000 | drp_pkg::HDR_BYTES);
        put16(drp_pkg::TYPE_NS); put16(1); put16(16'hFFFF); put16(16'hFFFF);
        put16(2);
        put16(16'hC000 | drp_pkg::HDR_BYTES);
        run_message(20);
        drain();
    endtask

    task automatic test_overlong();
        build_random();
        while (msg.size() < STORE_BYTES + 20) put8(8'($urandom));
        run_message(40);
    endtask

    task automatic test_random_traffic();
        int m;
        m = 0;
        while (n_items < 1750) begin
            if (m % 40 == 0) calm = ~calm;
            build_random();
            // some parses are abandoned by the next load
            run_message(($urandom_range(0, 9) == 0) ? $urandom_range(1, 4) : 600);
            if (m % 25 == 0) drain();
            if (m == 30) test_overlong();
            m++;
        end
    endtask

    // ---------------- token checker ----------------
    task automatic check_field(string name, longint unsigned e, longint unsigned a);
        if (e != a) begin
            $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, e, a);
            n_fail++;
        end
    endtask

    always @(posedge i_clk) begin
        drp_pkg::t_out_tok e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (token_q.size() == 0) begin
                $display("%0t: unexpected token %0h", $time, o_out_tok);
                n_fail++;
            end else begin
                e = token_q.pop_front();
                n_tokens++;
                check_field("token_kind", e.token_kind, o_out_tok.token_kind);
                check_field("section", e.section, o_out_tok.section);
                check_field("word_a", e.word_a, o_out_tok.word_a);
                check_field("word_b", e.word_b, o_out_tok.word_b);
                check_field("word_c", e.word_c, o_out_tok.word_c);
                check_field("word_d", e.word_d, o_out_tok.word_d);
                check_field("truncated", e.truncated, o_out_tok.truncated);
                check_field("response_code", e.response_code, o_out_tok.response_code);
                check_field("error_code", e.error_code, o_out_tok.error_code);
                check_field("last_token", e.last_token, o_out_tok.last_token);
            end
        end
    end

    // receiver throttle: random stall before each token
    initial begin
        int n;
        forever begin
            n = calm ? 0 : $urandom_range(0, 8);
            repeat (n) begin
                @(negedge i_clk);
                i_out_stall <= 1'b1;
            end
            @(negedge i_clk);
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    initial begin
        #30ms;
        $display("Simulation FAILED");
        $finish;
    end

    // ---------------- main sequence ----------------
    initial begin
        fill_cnt = 0; msg_len = 0; rd_ptr = 0; resume_ptr = 0; hops = 0;
        label_left = 0; rdata_left = 0; rec_end = 0;
        jumped = 0; dot_pend = 0; name_is_rdata = 0;
        sec_left = '{0, 0, 0, 0};
        phase = drp_pkg::PH_IDLE;
        n_items = 0; n_msgs = 0; n_tokens = 0; n_errtok = 0; n_fail = 0;
        calm = 1'b1;
        last_pred = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_fetch();
        test_header_only();
        test_short_message();
        test_pointer_loop();
        test_read_past_end();
        test_ns_and_odd_length();
        test_random_traffic();

        drain();
        repeat (40) @(posedge i_clk);
        $display("Sent %0d requests over %0d messages; %0d tokens checked, %0d of them errors.",
                 n_items, n_msgs, n_tokens, n_errtok);
        if (n_fail == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

>>> files.f
design/drp_pkg.sv
design/drp_ram.sv
design/dns_response_parser_unit.sv
tb/tb_dns_response_parser_unit.sv
